// File: hw/rtl/particle_update_distance_size_defines.svh
// Assertion shorthands for the top-level RTL file; clk and rst must be in scope.
`ifndef PARTICLE_UPDATE_DISTANCE_SIZE_DEFINES_SVH
`define PARTICLE_UPDATE_DISTANCE_SIZE_DEFINES_SVH

// Same-cycle implication.
`define PUD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PUD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/pud_pkg.sv
`timescale 1ns / 1ps
package pud_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 32;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_W        = 2;
  localparam int QCNT_W        = 3;
  localparam int SQRT_STEPS    = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAMERA_X     = 3'd0,
    REG_CAMERA_Y     = 3'd1,
    REG_CAMERA_Z     = 3'd2,
    REG_MIN_SIZE     = 3'd3,
    REG_MAX_SIZE     = 3'd4,
    REG_MAX_DISTANCE = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic signed [31:0] camera_x;
    logic signed [31:0] camera_y;
    logic signed [31:0] camera_z;
    logic [30:0]        min_size;
    logic [30:0]        max_size;
    logic [30:0]        max_distance;
  } cfg_t;

  // One classified particle, as it sits in the queue.
  typedef struct packed {
    logic signed [31:0] np_x;
    logic signed [31:0] np_y;
    logic signed [31:0] np_z;
    logic signed [31:0] life;
    logic [7:0]         colour;
    logic               far;
    logic [61:0]        sq_x;
    logic [61:0]        sq_y;
    logic [61:0]        sq_z;
  } item_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              full;
    logic              empty;
  } queue_stat_t;

endpackage

// File: hw/rtl/pud_if.sv
`timescale 1ns / 1ps
interface pud_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic signed [31:0] vel_z;
  logic signed [31:0] life_in;
  logic [30:0]        decay_rate;
  logic [30:0]        time_step;

  modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, life_in,
                  decay_rate, time_step, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, life_in,
                  decay_rate, time_step, output ready);
endinterface

interface pud_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] new_pos_x;
  logic signed [31:0] new_pos_y;
  logic signed [31:0] new_pos_z;
  logic signed [31:0] new_life;
  logic [7:0]         colour_level;
  logic signed [31:0] draw_size;

  modport source (output valid, new_pos_x, new_pos_y, new_pos_z, new_life, colour_level,
                  draw_size, input ready);
  modport sink   (input valid, new_pos_x, new_pos_y, new_pos_z, new_life, colour_level,
                  draw_size, output ready);
endinterface

// File: hw/rtl/pud_front.sv
`timescale 1ns / 1ps
module pud_front #(
  parameter int FRAC_BITS = pud_pkg::FRAC_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  pud_in_if.sink          in_ch,
  input  pud_pkg::cfg_t   cfg,
  input  logic            q_full,
  output logic            push,
  output pud_pkg::item_t  item
);

  logic en;

  // stage 1: products
  logic               v1;
  logic signed [31:0] pos1 [3];
  logic signed [63:0] pv1 [3];
  logic signed [31:0] life1;
  logic [61:0]        dp1;

  // stage 2: new position and life
  logic               v2;
  logic signed [31:0] np2 [3];
  logic signed [31:0] life2;
  logic signed [63:0] lw;
  logic signed [31:0] life_sat;

  // stage 3: camera offsets and colour product
  logic               v3;
  logic signed [31:0] np3 [3];
  logic signed [31:0] life3;
  logic [30:0]        a3 [3];
  logic [2:0]         far3;
  logic [38:0]        cprod3;
  logic signed [32:0] dd [3];
  logic [32:0]        aa [3];
  logic signed [31:0] cam [3];

  // stage 4: squares and colour
  logic               v4;
  logic signed [31:0] np4 [3];
  logic signed [31:0] life4;
  logic [61:0]        sq4 [3];
  logic               far4;
  logic [7:0]         colour4;

  assign en          = !q_full;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= in_ch.valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pos1[0] <= in_ch.pos_x;
      pos1[1] <= in_ch.pos_y;
      pos1[2] <= in_ch.pos_z;
      pv1[0]  <= in_ch.vel_x * $signed({1'b0, in_ch.time_step});
      pv1[1]  <= in_ch.vel_y * $signed({1'b0, in_ch.time_step});
      pv1[2]  <= in_ch.vel_z * $signed({1'b0, in_ch.time_step});
      life1   <= in_ch.life_in;
      dp1     <= in_ch.decay_rate * in_ch.time_step;
    end
  end

  // saturate life to the signed 32-bit range
  always_comb begin
    lw = $signed({{32{life1[31]}}, life1}) - $signed(64'(dp1 >> FRAC_BITS));
    if (!lw[63] && (|lw[62:31])) begin
      life_sat = 32'sh7FFF_FFFF;
    end else if (lw[63] && !(&lw[62:31])) begin
      life_sat = 32'sh8000_0000;
    end else begin
      life_sat = lw[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        np2[i] <= pos1[i] + pv1[i][FRAC_BITS+31:FRAC_BITS];
      end
      life2 <= life_sat;
    end
  end

  assign cam[0] = cfg.camera_x;
  assign cam[1] = cfg.camera_y;
  assign cam[2] = cfg.camera_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dd[i] = $signed({cam[i][31], cam[i]}) - $signed({np2[i][31], np2[i]});
      aa[i] = dd[i][32] ? 33'(-dd[i]) : 33'(dd[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        np3[i]  <= np2[i];
        a3[i]   <= aa[i][30:0];
        far3[i] <= |aa[i][32:31];
      end
      life3  <= life2;
      cprod3 <= (!life2[31] && (|life2[30:0])) ? 39'(life2[30:0] * 8'd255) : 39'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        np4[i] <= np3[i];
        sq4[i] <= a3[i] * a3[i];
      end
      life4   <= life3;
      far4    <= |far3;
      colour4 <= (|cprod3[38:FRAC_BITS+8]) ? 8'd255 : cprod3[FRAC_BITS+7:FRAC_BITS];
    end
  end

  assign push        = v4 && en;
  assign item.np_x   = np4[0];
  assign item.np_y   = np4[1];
  assign item.np_z   = np4[2];
  assign item.life   = life4;
  assign item.colour = colour4;
  assign item.far    = far4;
  assign item.sq_x   = sq4[0];
  assign item.sq_y   = sq4[1];
  assign item.sq_z   = sq4[2];

endmodule

// File: hw/rtl/pud_queue.sv
`timescale 1ns / 1ps
module pud_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  pud_pkg::item_t       wdata,
  input  logic                 pop,
  output pud_pkg::item_t       rdata,
  output pud_pkg::queue_stat_t stat
);

  pud_pkg::item_t                 mem [pud_pkg::QUEUE_DEPTH];
  logic [pud_pkg::QPTR_W-1:0]     wptr;
  logic [pud_pkg::QPTR_W-1:0]     rptr;
  logic [pud_pkg::QCNT_W-1:0]     count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop) rptr <= rptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= wdata;
  end

  assign rdata      = mem[rptr];
  assign stat.count = count;
  assign stat.full  = (count == pud_pkg::QCNT_W'(pud_pkg::QUEUE_DEPTH));
  assign stat.empty = (count == '0);

endmodule

// File: hw/rtl/pud_back.sv
`timescale 1ns / 1ps
module pud_back #(
  parameter int FRAC_BITS = pud_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  pud_pkg::cfg_t        cfg,
  input  pud_pkg::queue_stat_t qstat,
  input  pud_pkg::item_t       qdata,
  output logic                 pop,
  pud_out_if.source            out_ch
);

  localparam int SQ   = pud_pkg::SQRT_STEPS;
  localparam int DIV0 = SQ + 1;
  localparam int PROD = DIV0 + FRAC_BITS + 1;
  localparam int NST  = PROD + 1;

  typedef struct packed {
    logic signed [31:0]   np_x;
    logic signed [31:0]   np_y;
    logic signed [31:0]   np_z;
    logic signed [31:0]   life;
    logic [7:0]           colour;
    logic                 far;
    logic                 near;
    logic [63:0]          rad;
    logic [34:0]          rem;
    logic [31:0]          root;
    logic [30:0]          drem;
    logic [FRAC_BITS-1:0] q;
    logic signed [63:0]   prod;
  } stage_t;

  stage_t             st [NST];
  stage_t             nx [NST];
  logic [NST-1:0]     vld;
  logic               adv;
  logic               ov;
  logic signed [31:0] o_np_x;
  logic signed [31:0] o_np_y;
  logic signed [31:0] o_np_z;
  logic signed [31:0] o_life;
  logic [7:0]         o_colour;
  logic signed [31:0] o_size;

  // one result bit of the floor square root
  function automatic stage_t sqrt_step(stage_t s);
    stage_t     r;
    logic [34:0] r2;
    logic [34:0] trial;
    r     = s;
    r2    = {s.rem[32:0], s.rad[63:62]};
    trial = {1'b0, s.root, 2'b01};
    r.rad = {s.rad[61:0], 2'b00};
    if (r2 >= trial) begin
      r.rem  = r2 - trial;
      r.root = {s.root[30:0], 1'b1};
    end else begin
      r.rem  = r2;
      r.root = {s.root[30:0], 1'b0};
    end
    return r;
  endfunction

  function automatic stage_t div_setup(stage_t s, logic [30:0] maxd);
    stage_t r;
    r      = s;
    r.near = !s.far && (s.root < {1'b0, maxd});
    r.drem = s.root[30:0];
    r.q    = '0;
    return r;
  endfunction

  // one quotient bit of (dist << FRAC_BITS) / max_distance
  function automatic stage_t div_step(stage_t s, logic [30:0] maxd);
    stage_t      r;
    logic [31:0] t;
    r = s;
    t = {s.drem, 1'b0};
    if (t >= {1'b0, maxd}) begin
      r.drem = 31'(t - {1'b0, maxd});
      r.q    = {s.q[FRAC_BITS-2:0], 1'b1};
    end else begin
      r.drem = t[30:0];
      r.q    = {s.q[FRAC_BITS-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic stage_t size_prod(stage_t s, logic [30:0] mn, logic [30:0] mx);
    stage_t               r;
    logic [FRAC_BITS:0]   ratio;
    logic signed [31:0]   diff;
    r      = s;
    ratio  = s.near ? {1'b0, s.q} : ((FRAC_BITS+1)'(1) << FRAC_BITS);
    diff   = $signed({1'b0, mx}) - $signed({1'b0, mn});
    r.prod = diff * $signed({1'b0, ratio});
    return r;
  endfunction

  assign adv = !ov || out_ch.ready;
  assign pop = adv && !qstat.empty;

  for (genvar k = 0; k < NST; k++) begin : g_st
    if (k == 0) begin : g_load
      always_comb begin
        nx[0]        = '0;
        nx[0].np_x   = qdata.np_x;
        nx[0].np_y   = qdata.np_y;
        nx[0].np_z   = qdata.np_z;
        nx[0].life   = qdata.life;
        nx[0].colour = qdata.colour;
        nx[0].far    = qdata.far;
        nx[0].rad    = 64'(qdata.sq_x) + 64'(qdata.sq_y) + 64'(qdata.sq_z);
      end
    end else if (k <= SQ) begin : g_sqrt
      assign nx[k] = sqrt_step(st[k-1]);
    end else if (k == DIV0) begin : g_dsetup
      assign nx[k] = div_setup(st[k-1], cfg.max_distance);
    end else if (k < PROD) begin : g_div
      assign nx[k] = div_step(st[k-1], cfg.max_distance);
    end else begin : g_prod
      assign nx[k] = size_prod(st[k-1], cfg.min_size, cfg.max_size);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      ov  <= 1'b0;
    end else if (adv) begin
      vld <= {vld[NST-2:0], !qstat.empty};
      ov  <= vld[NST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < NST; k++) begin
        st[k] <= nx[k];
      end
      o_np_x   <= st[NST-1].np_x;
      o_np_y   <= st[NST-1].np_y;
      o_np_z   <= st[NST-1].np_z;
      o_life   <= st[NST-1].life;
      o_colour <= st[NST-1].colour;
      o_size   <= $signed({1'b0, cfg.min_size}) + st[NST-1].prod[FRAC_BITS+31:FRAC_BITS];
    end
  end

  assign out_ch.valid        = ov;
  assign out_ch.new_pos_x    = o_np_x;
  assign out_ch.new_pos_y    = o_np_y;
  assign out_ch.new_pos_z    = o_np_z;
  assign out_ch.new_life     = o_life;
  assign out_ch.colour_level = o_colour;
  assign out_ch.draw_size    = o_size;

endmodule

// File: hw/rtl/particle_update_distance_size.sv
`timescale 1ns / 1ps
// Channel   Dir  Transfer when          Payload
// in_ch     in   valid && ready         position, velocity, life, decay, dt
// out_ch    out  valid && ready         new position, life, colour, size
// cfg       in   cfg_we                 cfg_index selects register, cfg_data
//
// One particle per cycle while out_ch.ready stays high; the back computes the
// square root and the quotient one bit per pipeline stage.
// Front (4 stages) and back stall separately; a 4-entry queue sits between them.
// in_ch.ready drops only while that queue is full.
// rst is synchronous; it empties the pipes and loads the register defaults.
`include "particle_update_distance_size_defines.svh"
module particle_update_distance_size #(
  parameter int FRAC_BITS = pud_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  pud_in_if.sink                            in_ch,
  pud_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [pud_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pud_pkg::CFG_DATA_W-1:0]    cfg_data
);

  pud_pkg::cfg_t        cfg;
  pud_pkg::item_t       push_item;
  pud_pkg::item_t       head_item;
  pud_pkg::queue_stat_t q_stat;
  logic                 push;
  logic                 pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.camera_x     <= '0;
      cfg.camera_y     <= '0;
      cfg.camera_z     <= '0;
      cfg.min_size     <= 31'(1) << FRAC_BITS;
      cfg.max_size     <= 31'(1) << FRAC_BITS;
      cfg.max_distance <= 31'(1) << FRAC_BITS;
    end else if (cfg_we) begin
      unique case (pud_pkg::cfg_reg_t'(cfg_index))
        pud_pkg::REG_CAMERA_X:     cfg.camera_x     <= cfg_data;
        pud_pkg::REG_CAMERA_Y:     cfg.camera_y     <= cfg_data;
        pud_pkg::REG_CAMERA_Z:     cfg.camera_z     <= cfg_data;
        pud_pkg::REG_MIN_SIZE:     cfg.min_size     <= cfg_data[30:0];
        pud_pkg::REG_MAX_SIZE:     cfg.max_size     <= cfg_data[30:0];
        pud_pkg::REG_MAX_DISTANCE: cfg.max_distance <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  pud_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .cfg    (cfg),
    .q_full (q_stat.full),
    .push   (push),
    .item   (push_item)
  );

  pud_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (push_item),
    .pop   (pop),
    .rdata (head_item),
    .stat  (q_stat)
  );

  pud_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .qstat  (q_stat),
    .qdata  (head_item),
    .pop    (pop),
    .out_ch (out_ch)
  );

  `PUD_ASSERT_IMP(a_full_stall, q_stat.full, !in_ch.ready, "input taken while queue full")
  `PUD_ASSERT_NXT(a_queue_fill, push && !pop, !q_stat.empty, "queue lost a pushed item")
  `PUD_ASSERT_IMP(a_dead_dark, out_ch.valid && (out_ch.new_life[31] || out_ch.new_life == 32'sd0), out_ch.colour_level == 8'd0, "colour lit with no life")

endmodule

// File: sim/particle_update_distance_size_tb.sv
`timescale 1ns / 1ps
module particle_update_distance_size_tb;

  localparam int FB         = pud_pkg::FRAC_BITS_DEF;
  localparam int MAX_CYCLES = 400000;
  localparam int DRAIN_WAIT = 80;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] life_in;
    logic [30:0]        decay_rate;
    logic [30:0]        time_step;
  } particle_t;

  typedef struct packed {
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_pos_z;
    logic signed [31:0] new_life;
    logic [7:0]         colour_level;
    logic signed [31:0] draw_size;
  } update_t;

  typedef struct {
    particle_t p;
    bit        typed;
    update_t   res;
  } stim_row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [pud_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [pud_pkg::CFG_DATA_W-1:0] cfg_data;

  pud_in_if  in_ch();
  pud_out_if out_ch();

  particle_update_distance_size dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // shadow of the register file
  longint cam_x, cam_y, cam_z, size_lo, size_hi, dist_full;

  update_t pending_updates[$];
  int      n_sent, n_checked, n_mismatch;
  int      n_cycles;
  bit      quiet;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic update_t predict_update(particle_t p);
    update_t         u;
    longint          dt, life, colour, ratio, sz, d, step;
    longint          pos[3], vel[3], cam[3], np[3];
    longint unsigned sum, a, cam_dist;
    logic [31:0]     w;
    bit              far;
    dt  = longint'(p.time_step);
    pos = '{longint'(p.pos_x), longint'(p.pos_y), longint'(p.pos_z)};
    vel = '{longint'(p.vel_x), longint'(p.vel_y), longint'(p.vel_z)};
    cam = '{cam_x, cam_y, cam_z};
    life = longint'(p.life_in) - ((longint'(p.decay_rate) * dt) >>> FB);
    if (life > 64'sd2147483647) life = 64'sd2147483647;
    if (life < -64'sd2147483648) life = -64'sd2147483648;
    if (life <= 0) colour = 0;
    else begin
      colour = (life * 255) >>> FB;
      if (colour > 255) colour = 255;
    end
    sum = 0;
    far = 1'b0;
    for (int i = 0; i < 3; i++) begin
      step  = (vel[i] * dt) >>> FB;
      w     = 32'(pos[i] + step);
      np[i] = longint'($signed(w));
      d     = cam[i] - np[i];
      a     = (d < 0) ? longint'(-d) : d;
      if (a >= 64'h8000_0000) far = 1'b1;
      else sum = sum + a * a;
    end
    if (far) ratio = longint'(1) << FB;
    else begin
      cam_dist = floor_sqrt(sum);
      if (cam_dist >= dist_full) ratio = longint'(1) << FB;
      else ratio = longint'((cam_dist << FB) / longint'(dist_full));
    end
    sz = size_lo + (((size_hi - size_lo) * ratio) >>> FB);
    u.new_pos_x    = np[0][31:0];
    u.new_pos_y    = np[1][31:0];
    u.new_pos_z    = np[2][31:0];
    u.new_life     = life[31:0];
    u.colour_level = colour[7:0];
    u.draw_size    = sz[31:0];
    return u;
  endfunction

  task automatic write_reg(pud_pkg::cfg_reg_t idx, logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      pud_pkg::REG_CAMERA_X:     cam_x = longint'($signed(val));
      pud_pkg::REG_CAMERA_Y:     cam_y = longint'($signed(val));
      pud_pkg::REG_CAMERA_Z:     cam_z = longint'($signed(val));
      pud_pkg::REG_MIN_SIZE:     size_lo = longint'(val[30:0]);
      pud_pkg::REG_MAX_SIZE:     size_hi = longint'(val[30:0]);
      pud_pkg::REG_MAX_DISTANCE: dist_full = longint'(val[30:0]);
      default: ;
    endcase
  endtask

  // hold until the pipe is empty, then let it settle
  task automatic drain();
    while (pending_updates.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic send_particle(particle_t p, bit typed, update_t res);
    if (!quiet && $urandom_range(99) < 13) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.pos_x      <= p.pos_x;
    in_ch.pos_y      <= p.pos_y;
    in_ch.pos_z      <= p.pos_z;
    in_ch.vel_x      <= p.vel_x;
    in_ch.vel_y      <= p.vel_y;
    in_ch.vel_z      <= p.vel_z;
    in_ch.life_in    <= p.life_in;
    in_ch.decay_rate <= p.decay_rate;
    in_ch.time_step  <= p.time_step;
    do @(posedge clk); while (!in_ch.ready);
    pending_updates.push_back(typed ? res : predict_update(p));
    n_sent++;
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      4: return $urandom >> $urandom_range(4, 28);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_offset();
    return $unsigned($signed($urandom) >>> $urandom_range(6, 30));
  endfunction

  task automatic random_config();
    logic [31:0] md;
    write_reg(pud_pkg::REG_CAMERA_X, pick_word());
    write_reg(pud_pkg::REG_CAMERA_Y, pick_word());
    write_reg(pud_pkg::REG_CAMERA_Z, pick_word());
    write_reg(pud_pkg::REG_MIN_SIZE, pick_word() & 32'h7fff_ffff);
    write_reg(pud_pkg::REG_MAX_SIZE, pick_word() & 32'h7fff_ffff);
    md = pick_word() & 32'h7fff_ffff;
    if (md == 0) md = 32'd1;
    write_reg(pud_pkg::REG_MAX_DISTANCE, md);
  endtask

  function automatic particle_t random_particle();
    particle_t p;
    p.life_in    = pick_word();
    p.decay_rate = 31'(pick_word());
    if ($urandom_range(1)) begin
      // land near the camera so the size interpolation is exercised
      p.pos_x      = 32'(cam_x) + pick_offset();
      p.pos_y      = 32'(cam_y) + pick_offset();
      p.pos_z      = 32'(cam_z) + pick_offset();
      p.vel_x      = pick_offset();
      p.vel_y      = pick_offset();
      p.vel_z      = pick_offset();
      p.time_step  = 31'($urandom_range(0, 32'h0002_0000));
      p.decay_rate = 31'($urandom_range(0, 32'h0004_0000));
    end else begin
      p.pos_x     = pick_word();
      p.pos_y     = pick_word();
      p.pos_z     = pick_word();
      p.vel_x     = pick_word();
      p.vel_y     = pick_word();
      p.vel_z     = pick_word();
      p.time_step = 31'(pick_word());
    end
    return p;
  endfunction

  // sink side: random back-pressure
  always @(negedge clk) begin
    out_ch.ready <= quiet || ($urandom_range(99) >= 13);
  end

  always @(posedge clk) begin
    update_t got, want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.new_pos_x, out_ch.new_pos_y, out_ch.new_pos_z,
              out_ch.new_life, out_ch.colour_level, out_ch.draw_size};
      if (pending_updates.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("unexpected transfer: pos %h %h %h life %h colour %h size %h",
                   got.new_pos_x, got.new_pos_y, got.new_pos_z, got.new_life,
                   got.colour_level, got.draw_size);
      end else begin
        want = pending_updates.pop_front();
        n_checked++;
        if (got !== want) begin
          n_mismatch++;
          if (n_mismatch <= 10) begin
            $display("mismatch at result %0d", n_checked);
            $display("  expected pos %h %h %h life %h colour %h size %h",
                     want.new_pos_x, want.new_pos_y, want.new_pos_z, want.new_life,
                     want.colour_level, want.draw_size);
            $display("  actual   pos %h %h %h life %h colour %h size %h",
                     got.new_pos_x, got.new_pos_y, got.new_pos_z, got.new_life,
                     got.colour_level, got.draw_size);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > MAX_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               n_cycles, pending_updates.size());
      $display("particle_update_distance_size_tb: errors");
      $finish;
    end
  end

  stim_row_t table_reset[8];
  stim_row_t table_near[5];

  initial begin
    particle_t p;
    update_t   none;
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    in_ch.valid  = 1'b0;
    in_ch.pos_x  = '0;
    in_ch.pos_y  = '0;
    in_ch.pos_z  = '0;
    in_ch.vel_x  = '0;
    in_ch.vel_y  = '0;
    in_ch.vel_z  = '0;
    in_ch.life_in    = '0;
    in_ch.decay_rate = '0;
    in_ch.time_step  = '0;
    quiet      = 1'b0;
    n_sent     = 0;
    n_checked  = 0;
    n_mismatch = 0;
    n_cycles   = 0;
    none       = '0;
    cam_x = 0; cam_y = 0; cam_z = 0;
    size_lo = 64'd1 << FB; size_hi = 64'd1 << FB; dist_full = 64'd1 << FB;

    // rows at the reset settings: size is always 1.0 there
    table_reset[0] = '{'0, 1'b1, '{0, 0, 0, 0, 8'd0, 32'h0001_0000}};
    table_reset[1] = '{'{0, 0, 0, 0, 0, 0, 32'h0001_0000, 0, 0}, 1'b1,
                       '{0, 0, 0, 32'h0001_0000, 8'd255, 32'h0001_0000}};
    table_reset[2] = '{'{0, 0, 0, 0, 0, 0, 32'h7fff_ffff, 0, 0}, 1'b1,
                       '{0, 0, 0, 32'h7fff_ffff, 8'd255, 32'h0001_0000}};
    table_reset[3] = '{'{0, 0, 0, 0, 0, 0, 32'h8000_0000, 31'h7fff_ffff, 31'h7fff_ffff},
                       1'b1, '{0, 0, 0, 32'h8000_0000, 8'd0, 32'h0001_0000}};
    table_reset[4] = '{'{32'h8000_0000, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b1,
                       '{32'h8000_0000, 0, 0, 0, 8'd0, 32'h0001_0000}};
    table_reset[5] = '{'{0, 0, 0, 0, 0, 0, 32'h0000_8000, 0, 0}, 1'b1,
                       '{0, 0, 0, 32'h0000_8000, 8'd127, 32'h0001_0000}};
    table_reset[6] = '{'{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                         32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff, 31'h0001_0000,
                         31'h7fff_ffff}, 1'b0, none};
    table_reset[7] = '{'{0, 0, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                         32'h0001_0000, 31'h7fff_ffff, 31'd1}, 1'b0, none};
    // rows around a camera at (1, 2, -3), sent with shrinking and then growing size
    table_near[0] = '{'{32'h0001_0000, 32'h0002_0000, 32'hfffd_0000, 0, 0, 0,
                        32'h0001_0000, 0, 0}, 1'b0, none};
    table_near[1] = '{'{32'h0001_0000, 32'h0002_0000, 32'hfffd_0000, 32'h0000_0001, 0, 0,
                        32'h0001_0000, 0, 31'h0001_0000}, 1'b0, none};
    table_near[2] = '{'{32'h0001_8000, 32'h0002_0000, 32'hfffd_0000, 0, 0, 0,
                        32'h0000_4000, 31'h0000_4000, 31'h0001_0000}, 1'b0, none};
    table_near[3] = '{'{32'h0001_0000, 32'h0002_0000, 32'hfffd_0000, 32'h7fff_ffff, 0, 0,
                        32'hffff_0000, 0, 31'h7fff_ffff}, 1'b0, none};
    table_near[4] = '{'{32'h0000_ff00, 32'h0002_0010, 32'hfffd_0000, 0, 0, 0,
                        32'h0001_0000, 0, 0}, 1'b0, none};

    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (table_reset[i]) send_particle(table_reset[i].p, table_reset[i].typed,
                                           table_reset[i].res);
    in_ch.valid <= 1'b0;
    drain();

    write_reg(pud_pkg::REG_CAMERA_X, 32'h0001_0000);
    write_reg(pud_pkg::REG_CAMERA_Y, 32'h0002_0000);
    write_reg(pud_pkg::REG_CAMERA_Z, 32'hfffd_0000);
    write_reg(pud_pkg::REG_MIN_SIZE, 32'h7fff_ffff);
    write_reg(pud_pkg::REG_MAX_SIZE, 32'h0000_0000);
    write_reg(pud_pkg::REG_MAX_DISTANCE, 32'h0000_0001);
    foreach (table_near[i]) send_particle(table_near[i].p, 1'b0, none);
    in_ch.valid <= 1'b0;
    drain();

    write_reg(pud_pkg::REG_MAX_DISTANCE, 32'h7fff_ffff);
    write_reg(pud_pkg::REG_MIN_SIZE, 32'h0000_0000);
    write_reg(pud_pkg::REG_MAX_SIZE, 32'h7fff_ffff);
    foreach (table_near[i]) send_particle(table_near[i].p, 1'b0, none);
    in_ch.valid <= 1'b0;
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      random_config();
      for (int k = 0; k < 150; k++) begin
        // one whole phase runs with no idling on either side
        quiet = (ph == 2);
        p = random_particle();
        send_particle(p, 1'b0, none);
      end
      in_ch.valid <= 1'b0;
      quiet = 1'b0;
      drain();
    end

    $display("%0d particles sent, %0d updates checked over 8 register settings",
             n_sent, n_checked);
    $display("%0d mismatches, %0d updates left over", n_mismatch, pending_updates.size());
    if (n_mismatch == 0 && pending_updates.size() == 0) begin
      $display("particle_update_distance_size_tb: clean");
    end else begin
      $display("particle_update_distance_size_tb: errors");
    end
    $finish;
  end

endmodule
